### sv/chacha20_page_offset_randomizer_assert.svh
// Assertion macros for the page offset randomiser.
// Included by the modules that carry assertions; needs clk and rst_n in scope.
`ifndef CHACHA20_PAGE_OFFSET_RANDOMIZER_ASSERT_SVH
`define CHACHA20_PAGE_OFFSET_RANDOMIZER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CPOR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cpor: assertion failed");
`define CPOR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cpor: reset assertion failed");
`else
`define CPOR_ASSERT(lbl, prop)
`define CPOR_ASSERT_RST(lbl, prop)
`endif
`endif

### sv/cpor_pkg.sv
// Shared types and constants for the page offset randomiser.
// No dependencies; imported by every module of the block.
package cpor_pkg;

  localparam int ADDR_W = 64;
  localparam int WORD_W = 32;
  localparam int IN_W   = 2 * ADDR_W;
  localparam int CFG_W  = 64;
  localparam int CFG_AW = 3;

  // "expand 32-byte k", word 0 in the lowest slot
  localparam logic [3:0][WORD_W-1:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  localparam logic [WORD_W-1:0] CTR_RESET = 32'd16;
  localparam logic [WORD_W-1:0] CTR_STEP  = 32'd2;

  typedef enum logic [CFG_AW-1:0] {
    CFG_KEY_01   = 3'd0,
    CFG_KEY_23   = 3'd1,
    CFG_KEY_45   = 3'd2,
    CFG_KEY_67   = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KS,
    ST_MOD,
    ST_OUT
  } cpor_state_t;

  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

### sv/cpor_qr_half.sv
// One half of a ChaCha quarter round: two add-xor-rotate steps.
// Half 0 rotates by 16 and 12, half 1 by 8 and 7. Uses cpor_pkg.
module cpor_qr_half (
  input  logic                      half_i,
  input  logic [cpor_pkg::WORD_W-1:0] a_i,
  input  logic [cpor_pkg::WORD_W-1:0] b_i,
  input  logic [cpor_pkg::WORD_W-1:0] c_i,
  input  logic [cpor_pkg::WORD_W-1:0] d_i,
  output logic [cpor_pkg::WORD_W-1:0] a_o,
  output logic [cpor_pkg::WORD_W-1:0] b_o,
  output logic [cpor_pkg::WORD_W-1:0] c_o,
  output logic [cpor_pkg::WORD_W-1:0] d_o
);
  import cpor_pkg::*;

  logic [WORD_W-1:0] dx;
  logic [WORD_W-1:0] bx;

  always_comb begin
    a_o = a_i + b_i;
    dx  = d_i ^ a_o;
    d_o = half_i ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
    c_o = c_i + d_o;
    bx  = b_i ^ c_o;
    b_o = half_i ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
  end

endmodule

### sv/cpor_core.sv
// ChaCha block core: 16-word state register and four shared half-round lanes.
// One half quarter round per lane per cycle. Uses cpor_pkg and cpor_qr_half.
module cpor_core #(
  parameter int ROUNDS = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cpor_pkg::unit_ctl_t              ctl_i,
  input  logic [7:0][cpor_pkg::WORD_W-1:0] key_i,
  input  logic [cpor_pkg::WORD_W-1:0]      ctr_i,
  input  logic [2:0][cpor_pkg::WORD_W-1:0] nonce_i,
  output cpor_pkg::unit_st_t               st_o,
  output logic [cpor_pkg::ADDR_W-1:0]      low64_o
);
  import cpor_pkg::*;

  localparam int STEPS = 2 * ROUNDS;
  localparam int SW    = $clog2(STEPS);
  localparam logic [SW-1:0] LAST = SW'(STEPS - 1);

  logic [15:0][WORD_W-1:0] w_r, w_nxt;
  logic [SW-1:0]           step_r, step_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;

  logic              diag;
  logic [3:0][1:0]   bi, ci, di;
  logic [3:0][WORD_W-1:0] la, lb, lc, ld, oa, ob, oc, od;

  // bit 0 picks the half, bit 1 the round parity (columns first)
  assign diag = step_r[1];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign bi[l] = 2'(l) + {1'b0, diag};
    assign ci[l] = 2'(l) + {diag, 1'b0};
    assign di[l] = 2'(l) + {diag, diag};
    assign la[l] = w_r[{2'b00, 2'(l)}];
    assign lb[l] = w_r[{2'b01, bi[l]}];
    assign lc[l] = w_r[{2'b10, ci[l]}];
    assign ld[l] = w_r[{2'b11, di[l]}];

    cpor_qr_half u_qr (
      .half_i (step_r[0]),
      .a_i    (la[l]),
      .b_i    (lb[l]),
      .c_i    (lc[l]),
      .d_i    (ld[l]),
      .a_o    (oa[l]),
      .b_o    (ob[l]),
      .c_o    (oc[l]),
      .d_o    (od[l])
    );
  end

  always_comb begin
    w_nxt    = w_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl_i.start) begin
      w_nxt[3:0]   = SIGMA;
      w_nxt[11:4]  = key_i;
      w_nxt[12]    = ctr_i;
      w_nxt[15:13] = nonce_i;
      step_nxt     = '0;
      busy_nxt     = 1'b1;
    end else if (busy_r) begin
      for (int l = 0; l < 4; l++) begin
        w_nxt[{2'b00, 2'(l)}]  = oa[l];
        w_nxt[{2'b01, bi[l]}] = ob[l];
        w_nxt[{2'b10, ci[l]}] = oc[l];
        w_nxt[{2'b11, di[l]}] = od[l];
      end
      step_nxt = step_r + 1'b1;
      if (step_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // feed-forward needs only the constant words 0 and 1
  assign low64_o    = {w_r[1] + SIGMA[1], w_r[0] + SIGMA[0]};
  assign st_o.busy = busy_r;
  assign st_o.done = done_r;

endmodule

### sv/cpor_mod.sv
// Bit-serial restoring remainder: 64-bit dividend, one quotient bit per cycle.
// Divisor must be non-zero at start. Uses cpor_pkg.
module cpor_mod #(
  parameter int DIV_W = 52
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cpor_pkg::unit_ctl_t         ctl_i,
  input  logic [cpor_pkg::ADDR_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]            divisor_i,
  output cpor_pkg::unit_st_t          st_o,
  output logic [DIV_W-1:0]            rem_o
);
  import cpor_pkg::*;

  localparam int CW = $clog2(ADDR_W);
  localparam logic [CW-1:0] LAST = CW'(ADDR_W - 1);

  logic [ADDR_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[ADDR_W-1]};
    if (ctl_i.start) begin
      dvd_nxt  = dividend_i;
      div_nxt  = divisor_i;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      dvd_nxt = {dvd_r[ADDR_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rem_o      = rem_r;
  assign st_o.busy = busy_r;
  assign st_o.done = done_r;

endmodule

### sv/chacha20_page_offset_randomizer.sv
// Page offset randomiser. Each input beat carries a base address and a shift limit in
// bytes; the output beat is base + ((chacha_low64 % pages) << PAGE_BITS), mod 2^64,
// where pages = shift_limit >> PAGE_BITS. With zero pages the base passes straight to
// ST_OUT and the output register, and the block counter is left alone. Otherwise the
// block counter (reset 16) is used for one ChaCha block and then advances by 2; the
// block runs in the four half-round lanes, then the remainder unit takes one quotient
// bit per cycle, then the sum goes through ST_OUT to the output register. One item at
// a time; a finished beat may wait at the output while the next input is taken. The
// user must write configuration only while idle; the block does not enforce it.
module chacha20_page_offset_randomizer #(
  parameter int PAGE_BITS = 12,
  parameter int ROUNDS    = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [63:0] base_address, [127:64] shift_limit
  input  logic [cpor_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [63:0] placed_address
  output logic [cpor_pkg::ADDR_W-1:0] out_tdata,
  input  logic                        cfg_we,
  input  logic [cpor_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [cpor_pkg::CFG_W-1:0]  cfg_wdata
);
  import cpor_pkg::*;

  `include "chacha20_page_offset_randomizer_assert.svh"

  localparam int DIV_W = ADDR_W - PAGE_BITS;

  cpor_state_t state_r, state_nxt;

  logic [7:0][WORD_W-1:0] key_r;
  logic [2:0][WORD_W-1:0] nonce_r;
  logic [WORD_W-1:0]      ctr_r, ctr_nxt;
  logic [ADDR_W-1:0]      base_r, base_nxt;
  logic [DIV_W-1:0]       pages_r, pages_nxt;
  logic [ADDR_W-1:0]      res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]      out_data_r, out_data_nxt;

  logic [DIV_W-1:0]  pages_in;
  logic              in_acc;
  unit_ctl_t         ks_ctl, md_ctl;
  unit_st_t          ks_st, md_st;
  logic [ADDR_W-1:0] ks_low64;
  logic [DIV_W-1:0]  md_rem;

  assign pages_in = in_tdata[IN_W-1:ADDR_W+PAGE_BITS];
  assign in_acc   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_KEY_01:   key_r[1:0]   <= cfg_wdata;
        CFG_KEY_23:   key_r[3:2]   <= cfg_wdata;
        CFG_KEY_45:   key_r[5:4]   <= cfg_wdata;
        CFG_KEY_67:   key_r[7:6]   <= cfg_wdata;
        CFG_NONCE_LO: nonce_r[1:0] <= cfg_wdata;
        CFG_NONCE_HI: nonce_r[2]   <= cfg_wdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  cpor_core #(
    .ROUNDS (ROUNDS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ks_ctl),
    .key_i   (key_r),
    .ctr_i   (ctr_r),
    .nonce_i (nonce_r),
    .st_o    (ks_st),
    .low64_o (ks_low64)
  );

  cpor_mod #(
    .DIV_W (DIV_W)
  ) u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (md_ctl),
    .dividend_i (ks_low64),
    .divisor_i  (pages_r),
    .st_o       (md_st),
    .rem_o      (md_rem)
  );

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    pages_r    <= pages_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctr_r       <= CTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctr_nxt       = ctr_r;
    base_nxt      = base_r;
    pages_nxt     = pages_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    ks_ctl.start  = 1'b0;
    md_ctl.start  = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          base_nxt  = in_tdata[ADDR_W-1:0];
          pages_nxt = pages_in;
          if (pages_in == '0) begin
            res_nxt   = in_tdata[ADDR_W-1:0];
            state_nxt = ST_OUT;
          end else begin
            // launch captures the current counter; the discarded block is the +1
            ks_ctl.start = 1'b1;
            ctr_nxt      = ctr_r + CTR_STEP;
            state_nxt    = ST_KS;
          end
        end
      end
      ST_KS: begin
        if (ks_st.done) begin
          md_ctl.start = 1'b1;
          state_nxt    = ST_MOD;
        end
      end
      ST_MOD: begin
        if (md_st.done) begin
          res_nxt   = base_r + (ADDR_W'(md_rem) << PAGE_BITS);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `CPOR_ASSERT(a_ks_done_in_ks, ks_st.done |-> (state_r == ST_KS))
  `CPOR_ASSERT(a_md_done_in_mod, md_st.done |-> (state_r == ST_MOD))
  `CPOR_ASSERT(a_ctr_moves_on_launch, !$stable(ctr_r) |-> $past(ks_ctl.start))
  `CPOR_ASSERT(a_bypass_keeps_ctr, (in_acc && (pages_in == '0)) |=> $stable(ctr_r))
  `CPOR_ASSERT_RST(a_reset_clears_out, !rst_n |=> (!out_tvalid && in_tready))

endmodule

### tb/sv/cpor_placement_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the page offset randomiser: tracks config writes and both streams,
// predicts every placed address with its own ChaCha block model and checks in order.
// Depends on cpor_pkg only.
module cpor_placement_checker #(
  parameter int PAGE_BITS = 12,
  parameter int ROUNDS    = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  // [63:0] base_address, [127:64] shift_limit
  input  logic [cpor_pkg::IN_W-1:0]   in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  // [63:0] placed_address
  input  logic [cpor_pkg::ADDR_W-1:0] out_tdata,
  input  logic                        cfg_we,
  input  logic [cpor_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [cpor_pkg::CFG_W-1:0]  cfg_wdata,
  output int                          err_count,
  output int                          pending,
  output int                          n_results,
  output int                          n_shifted
);
  import cpor_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [WORD_W-1:0] key_word [8];
  logic [WORD_W-1:0] nonce_word [3];
  logic [WORD_W-1:0] blk_ctr;
  logic [ADDR_W-1:0] placed_q [$];

  initial begin
    err_count = 0;
    pending   = 0;
    n_results = 0;
    n_shifted = 0;
  end

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic logic [4*WORD_W-1:0] quarter(input logic [WORD_W-1:0] a, b, c, d);
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {d, c, b, a};
  endfunction

  // words 0 and 1 of the block at counter ctr, word 0 in the low half
  function automatic logic [ADDR_W-1:0] keystream_lo64(input logic [WORD_W-1:0] ctr);
    logic [WORD_W-1:0] s [16];
    logic [WORD_W-1:0] x [16];
    int i;
    int r;
    for (i = 0; i < 4; i++) s[i] = SIGMA[i];
    for (i = 0; i < 8; i++) s[4+i] = key_word[i];
    s[12] = ctr;
    for (i = 0; i < 3; i++) s[13+i] = nonce_word[i];
    for (i = 0; i < 16; i++) x[i] = s[i];
    // column rounds on even passes, diagonal on odd
    for (r = 0; r < ROUNDS; r++) begin
      if (r % 2 == 0) begin
        {x[12], x[8], x[4], x[0]}  = quarter(x[0], x[4], x[8], x[12]);
        {x[13], x[9], x[5], x[1]}  = quarter(x[1], x[5], x[9], x[13]);
        {x[14], x[10], x[6], x[2]} = quarter(x[2], x[6], x[10], x[14]);
        {x[15], x[11], x[7], x[3]} = quarter(x[3], x[7], x[11], x[15]);
      end else begin
        {x[15], x[10], x[5], x[0]} = quarter(x[0], x[5], x[10], x[15]);
        {x[12], x[11], x[6], x[1]} = quarter(x[1], x[6], x[11], x[12]);
        {x[13], x[8], x[7], x[2]}  = quarter(x[2], x[7], x[8], x[13]);
        {x[14], x[9], x[4], x[3]}  = quarter(x[3], x[4], x[9], x[14]);
      end
    end
    return {x[1] + s[1], x[0] + s[0]};
  endfunction

  always @(posedge clk) begin : watch
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] shift;
    logic [ADDR_W-1:0] pages;
    logic [ADDR_W-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) key_word[i] = '0;
      for (int i = 0; i < 3; i++) nonce_word[i] = '0;
      blk_ctr = CTR_RESET;
      placed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_KEY_01:   {key_word[1], key_word[0]} = cfg_wdata;
          CFG_KEY_23:   {key_word[3], key_word[2]} = cfg_wdata;
          CFG_KEY_45:   {key_word[5], key_word[4]} = cfg_wdata;
          CFG_KEY_67:   {key_word[7], key_word[6]} = cfg_wdata;
          CFG_NONCE_LO: {nonce_word[1], nonce_word[0]} = cfg_wdata;
          CFG_NONCE_HI: nonce_word[2] = cfg_wdata[WORD_W-1:0];
          default: ;  // unused index: nothing changes
        endcase
      end
      if (in_tvalid && in_tready) begin
        base  = in_tdata[ADDR_W-1:0];
        shift = in_tdata[IN_W-1:ADDR_W];
        pages = shift >> PAGE_BITS;
        if (pages == '0) begin
          want = base;
        end else begin
          want    = base + ((keystream_lo64(blk_ctr) % pages) << PAGE_BITS);
          blk_ctr = blk_ctr + CTR_STEP;
          n_shifted++;
        end
        placed_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        n_results++;
        if (placed_q.size() == 0) begin
          if (err_count < MAX_REPORTS)
            $display("result beat %0d: unexpected placed_address %h, nothing pending",
                     n_results, out_tdata);
          err_count++;
        end else begin
          want = placed_q.pop_front();
          if (out_tdata !== want) begin
            if (err_count < MAX_REPORTS)
              $display("result beat %0d: placed_address expected %h, got %h",
                       n_results, want, out_tdata);
            err_count++;
          end
        end
      end
    end
    pending = placed_q.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Bench top for the page offset randomiser: clock, reset, key/nonce phases and
// bursty request stimulus against a stalling receiver. Needs cpor_pkg, the block
// and cpor_placement_checker, which does all the checking.
module tb_top;
  import cpor_pkg::*;

  localparam int PAGE_BITS     = 12;
  localparam int ROUNDS        = 20;
  localparam int N_SETTINGS    = 8;
  localparam int PER_SETTING   = 217;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 2 * ROUNDS + 100;
  localparam int CYCLE_LIMIT   = 1_500_000;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_AW-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_SPARE_7 = 3'd7;

  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] ALT_A    = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [ADDR_W-1:0] ALT_5    = 64'h5555_5555_5555_5555;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [ADDR_W-1:0] out_tdata;
  logic              cfg_we     = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [CFG_W-1:0]  cfg_wdata  = '0;

  logic     in_taken     = 1'b0;
  int       err_count;
  int       pending;
  int       n_results;
  int       n_shifted;
  int       cycles       = 0;
  int       burst_left   = 0;
  int       n_cfg_writes = 0;
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_left      = 0;

  always #10 clk = ~clk;

  chacha20_page_offset_randomizer #(
    .PAGE_BITS (PAGE_BITS),
    .ROUNDS    (ROUNDS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  cpor_placement_checker #(
    .PAGE_BITS (PAGE_BITS),
    .ROUNDS    (ROUNDS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .err_count  (err_count),
    .pending    (pending),
    .n_results  (n_results),
    .n_shifted  (n_shifted)
  );

  // input beat taken at the edge just gone; read at the following falling edge
  always @(posedge clk) in_taken <= in_tvalid && in_tready;

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver back-pressure: modes held for random stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 400);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready = 1'b1;
      RX_COIN:   out_tready = 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready = ($urandom_range(0, 15) == 0);
      default:   out_tready = ~out_tready;
    endcase
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] rand_base();
    int r;
    logic [ADDR_W-1:0] v;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      v = ALL_ONES - 64'($urandom_range(0, 1 << 20));  // close to the top, offsets wrap
    end else if (r == 1) begin
      v = 64'($urandom);
    end else begin
      v = rand64();
    end
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_shift();
    int r;
    int k;
    logic [ADDR_W-1:0] pages;
    logic [ADDR_W-1:0] low;
    r   = $urandom_range(0, 99);
    low = 64'($urandom_range(0, (1 << PAGE_BITS) - 1));
    if (r < 3) begin
      return '0;
    end else if (r < 12) begin
      return low;  // under one page: pass-through
    end else if (r < 40) begin
      pages = 64'($urandom_range(1, 64));
      return (pages << PAGE_BITS) | low;
    end else if (r < 60) begin
      k     = $urandom_range(0, ADDR_W - 1 - PAGE_BITS);
      pages = 64'd1 << k;
      if ($urandom_range(0, 1) == 1) pages = pages - 64'd1;
      return (pages << PAGE_BITS) | low;
    end else if (r < 68) begin
      return ALL_ONES - 64'($urandom_range(0, 1 << 16));
    end
    return rand64();
  endfunction

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    n_cfg_writes++;
  endtask

  task automatic load_setting(input int s);
    logic [CFG_W-1:0] val;
    for (int i = 0; i <= CFG_NONCE_HI; i++) begin
      case (s)
        0:       val = ALL_ONES;
        1:       val = '0;
        2:       val = (i % 2 == 0) ? ALT_A : ALT_5;
        3:       val = (i % 2 == 0) ? ALT_5 : ALT_A;
        default: val = rand64();
      endcase
      cfg_write(i[CFG_AW-1:0], val);
    end
    cfg_write(CFG_SPARE_6, rand64());
    cfg_write(CFG_SPARE_7, rand64());
  endtask

  // one request beat; bursts of random length with random gaps between them
  task automatic push_request(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] shift);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0)
        gap = 0;
      else if ($urandom_range(0, 7) == 0)
        gap = $urandom_range(40, 250);
      else
        gap = $urandom_range(1, 30);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid = 1'b1;
    in_tdata  = {shift, base};
    do @(negedge clk); while (!in_taken);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_tvalid  = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed requests on the all-zero key left by reset
    push_request('0, '0);
    push_request(ALL_ONES, '0);
    push_request(ALL_ONES, 64'h0000_0000_0000_0FFF);  // just under a page
    push_request(64'h0123_4567_89AB_CDEF, 64'h0000_0000_0000_1000);  // one page
    push_request('0, 64'h0000_0000_0000_1FFF);
    push_request('0, 64'h0000_0000_0000_2000);
    push_request(ALL_ONES, 64'h0000_0000_0000_2000);  // wraps past 2^64
    push_request(ALL_ONES, ALL_ONES);
    push_request('0, ALL_ONES);
    push_request(ALT_A, ALT_5);
    push_request(ALT_5, ALT_A);
    push_request(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    push_request(64'hFFFF_FFFF_FFFF_F000, 64'h0000_0000_0010_0000);
    push_request(64'h0000_0000_0000_0FFF, 64'h0000_0000_0000_3000);
    push_request(64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
    wait_idle();

    for (int s = 0; s < N_SETTINGS; s++) begin
      load_setting(s);
      for (int n = 0; n < PER_SETTING; n++) push_request(rand_base(), rand_shift());
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d requests (%0d drew a ChaCha block, the rest passed through) over %0d",
             n_results, n_shifted, N_SETTINGS + 1);
    $display("key/nonce settings with %0d config writes, spare indexes and wide nonce data.",
             n_cfg_writes);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", err_count, pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/cpor_pkg.sv
sv/cpor_qr_half.sv
sv/cpor_core.sv
sv/cpor_mod.sv
sv/chacha20_page_offset_randomizer.sv
tb/sv/cpor_placement_checker.sv
tb/sv/tb_top.sv
